// ===== rtl/core/closest_pair_between_two_sets_top_defines.svh =====
// Assertion macros shared by the closest pair checker.
`ifndef CLOSEST_PAIR_BETWEEN_TWO_SETS_TOP_DEFINES_SVH
`define CLOSEST_PAIR_BETWEEN_TWO_SETS_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define CPBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("closest pair checker: same-cycle property failed");

// Next-cycle implication, masked while reset is asserted.
`define CPBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("closest pair checker: next-cycle property failed");

// Next-cycle implication that is checked through reset as well.
`define CPBS_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("closest pair checker: reset property failed");

`endif

// ===== rtl/core/cpbs_pkg.sv =====
// Shared types and constants for the closest pair search block.
package cpbs_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 20;

  localparam int LIMIT_W     = 21;
  localparam int INDEX_OUT_W = 8;

  // 99999.0 with four fraction bits.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1599984;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND_A = 2'd1,
    OP_APPEND_B = 2'd2,
    OP_SEARCH   = 2'd3
  } cpbs_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_DONE
  } cpbs_state_t;

endpackage

// ===== rtl/core/closest_pair_between_two_sets_top.sv =====
// Top level of the two-set closest pair search block.
//
// Usage: items enter on the in_ channel (in_valid / in_stall). A clear item
// empties both point sets and the overflow flag; an append item writes one
// point into set A or set B, or sets the overflow flag if that set is full.
// Appends stream in at one item per clock while no search runs. A search
// item scans every A point against every B point in A-major order and
// delivers exactly one result item on the out_ channel (out_valid /
// out_stall); clears and appends deliver nothing. A search issues one point
// pair per cycle from the two point memories, then drains the read, diff,
// square and compare stages and, when a pair was found, computes the root
// bit by bit in the square root unit. The pair scan is bound by one read
// port per memory. in_stall is high for the whole search.
// The result sits in an output register: while the receiver stalls it holds,
// and the block still takes new clear and append items; a later search
// waits at its end until that register is free.
// The distance limit is written on the cfg_ channel, which is always ready.
// Reset (rst_n, synchronous, active low) empties both sets, clears the
// overflow flag, restores the limit to 99999.0 and drops any result.
module closest_pair_between_two_sets_top
  import cpbs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_pair_found,
  output logic [INDEX_OUT_W-1:0]       out_index_a,
  output logic [INDEX_OUT_W-1:0]       out_index_b,
  output logic [LIMIT_W-1:0]           out_best_distance,
  output logic                         out_overflowed,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [LIMIT_W-1:0]           cfg_distance_limit
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int DW     = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DW;
  localparam int SUM_W  = SQ_W + 1;
  localparam int LSQ_W  = 2 * LIMIT_W;
  localparam int BEST_W = (SUM_W > LSQ_W) ? SUM_W : LSQ_W;
  localparam int ROOT_W = (BEST_W + 1) / 2;

  // Control state.
  cpbs_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   count_a_r, count_b_r;
  logic               overflow_r;
  logic [LIMIT_W-1:0] limit_r;

  // Point memories, one entry per point holding {x, y}.
  logic [PT_W-1:0] mem_a [MAX_POINTS];
  logic [PT_W-1:0] mem_b [MAX_POINTS];
  logic [PT_W-1:0] rd_a_r, rd_b_r;

  logic     accept;
  cpbs_op_t op;
  logic     room_a, room_b;

  // Scan counters and pipeline.
  logic [IDX_W-1:0] ia_r, ib_r;
  logic             last_a, last_b, scan_last;
  logic             issue;
  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] ia1_r, ib1_r, ia2_r, ib2_r, ia3_r, ib3_r;
  logic [DW-1:0]    dx_r, dy_r;
  logic signed [DW-1:0] dx_s, dy_s;
  logic [SQ_W-1:0]  sqx_r, sqy_r;
  logic [SUM_W-1:0] sum_sq;
  logic             closer;
  logic             pipe_empty;

  // Best pair so far.
  logic [LSQ_W-1:0]  limit_sq;
  logic [BEST_W-1:0] best_sq_r;
  logic [IDX_W-1:0]  best_a_r, best_b_r;
  logic              found_r;
  logic [LIMIT_W-1:0] dist_r;

  // Square root and result.
  logic              root_start;
  logic              root_done;
  logic [ROOT_W-1:0] root_val;
  logic              out_free;
  logic              out_load;
  logic [IDX_W+INDEX_OUT_W-1:0] best_a_ext, best_b_ext;

  logic                   out_valid_r;
  logic                   out_pair_found_r;
  logic [INDEX_OUT_W-1:0] out_index_a_r, out_index_b_r;
  logic [LIMIT_W-1:0]     out_best_distance_r;
  logic                   out_overflowed_r;

  assign accept = in_valid && !in_stall;
  assign op     = cpbs_op_t'(in_operation);
  assign room_a = (count_a_r < CNT_W'(MAX_POINTS));
  assign room_b = (count_b_r < CNT_W'(MAX_POINTS));

  // Change the limit only while idle; the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_distance_limit;
    end
  end

  // Set sizes and the sticky overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r  <= '0;
      count_b_r  <= '0;
      overflow_r <= 1'b0;
    end else if (accept) begin
      case (op)
        OP_CLEAR: begin
          count_a_r  <= '0;
          count_b_r  <= '0;
          overflow_r <= 1'b0;
        end
        OP_APPEND_A: begin
          if (room_a) begin
            count_a_r <= count_a_r + CNT_W'(1);
          end else begin
            overflow_r <= 1'b1;
          end
        end
        OP_APPEND_B: begin
          if (room_b) begin
            count_b_r <= count_b_r + CNT_W'(1);
          end else begin
            overflow_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Writes happen only in idle; the read port runs every cycle, and its data
  // is used only for pairs issued during a scan.
  always_ff @(posedge clk) begin
    if (accept && (op == OP_APPEND_A) && room_a) begin
      mem_a[count_a_r[IDX_W-1:0]] <= {in_point_x, in_point_y};
    end
    rd_a_r <= mem_a[ia_r];
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_APPEND_B) && room_b) begin
      mem_b[count_b_r[IDX_W-1:0]] <= {in_point_x, in_point_y};
    end
    rd_b_r <= mem_b[ib_r];
  end

  // A-major pair walk: B index runs fastest.
  assign last_a    = ((CNT_W'(ia_r) + CNT_W'(1)) == count_a_r);
  assign last_b    = ((CNT_W'(ib_r) + CNT_W'(1)) == count_b_r);
  assign scan_last = last_a && last_b;

  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == ST_IDLE)) begin
      ia_r <= '0;
      ib_r <= '0;
    end else if (issue) begin
      if (last_b) begin
        ib_r <= '0;
        ia_r <= ia_r + IDX_W'(1);
      end else begin
        ib_r <= ib_r + IDX_W'(1);
      end
    end
  end

  // Stage valids: read data, absolute differences, squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign pipe_empty = !v1_r && !v2_r && !v3_r;

  assign dx_s = DW'($signed(rd_a_r[PT_W-1:COORD_BITS])) -
                DW'($signed(rd_b_r[PT_W-1:COORD_BITS]));
  assign dy_s = DW'($signed(rd_a_r[COORD_BITS-1:0])) -
                DW'($signed(rd_b_r[COORD_BITS-1:0]));

  always_ff @(posedge clk) begin
    ia1_r <= ia_r;
    ib1_r <= ib_r;
    ia2_r <= ia1_r;
    ib2_r <= ib1_r;
    ia3_r <= ia2_r;
    ib3_r <= ib2_r;
    dx_r  <= dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
    dy_r  <= dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
    sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
  end

  assign sum_sq   = SUM_W'(sqx_r) + SUM_W'(sqy_r);
  assign closer   = (BEST_W'(sum_sq) < best_sq_r);
  assign limit_sq = LSQ_W'(limit_r) * LSQ_W'(limit_r);

  // Strict compare keeps the first of equal pairs in scan order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      best_a_r <= '0;
      best_b_r <= '0;
    end else if (accept && (op == OP_SEARCH)) begin
      found_r  <= 1'b0;
      best_a_r <= '0;
      best_b_r <= '0;
    end else if (v3_r && closer) begin
      found_r  <= 1'b1;
      best_a_r <= ia3_r;
      best_b_r <= ib3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_SEARCH)) begin
      best_sq_r <= BEST_W'(limit_sq);
    end else if (v3_r && closer) begin
      best_sq_r <= BEST_W'(sum_sq);
    end
  end

  cpbs_isqrt #(
    .VAL_W(BEST_W)
  ) u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(root_start),
    .value(best_sq_r),
    .done (root_done),
    .root (root_val)
  );

  // Reported distance: the root when a pair was found, else the limit.
  always_ff @(posedge clk) begin
    if ((state_r == ST_DRAIN) && pipe_empty && !found_r) begin
      dist_r <= limit_r;
    end else if ((state_r == ST_ROOT) && root_done) begin
      dist_r <= root_val[LIMIT_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op == OP_SEARCH)) begin
          if ((count_a_r == '0) || (count_b_r == '0)) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = found_r ? ST_ROOT : ST_DONE;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall   = 1'b1;
    issue      = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall   = 1'b0;
      ST_SCAN:  issue      = 1'b1;
      ST_DRAIN: root_start = pipe_empty && found_r;
      ST_ROOT:  begin
      end
      ST_DONE:  out_load   = out_free;
      default:  begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  assign best_a_ext = {INDEX_OUT_W'(0), best_a_r};
  assign best_b_ext = {INDEX_OUT_W'(0), best_b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pair_found_r    <= found_r;
      out_index_a_r       <= best_a_ext[INDEX_OUT_W-1:0];
      out_index_b_r       <= best_b_ext[INDEX_OUT_W-1:0];
      out_best_distance_r <= dist_r;
      out_overflowed_r    <= overflow_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pair_found    = out_pair_found_r;
  assign out_index_a       = out_index_a_r;
  assign out_index_b       = out_index_b_r;
  assign out_best_distance = out_best_distance_r;
  assign out_overflowed    = out_overflowed_r;

endmodule

// ===== rtl/core/cpbs_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module cpbs_isqrt
  import cpbs_pkg::*;
#(
  parameter int VAL_W = 2 * LIMIT_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VAL_W-1:0]       value,
  output logic                   done,
  output logic [(VAL_W+1)/2-1:0] root
);

  localparam int RW    = (VAL_W + 1) / 2;
  localparam int PAD_W = 2 * RW;
  localparam int REM_W = RW + 2;
  localparam int CAT_W = RW + 4;
  localparam int CNT_W = $clog2(RW + 1);

  logic [PAD_W-1:0] val_r;
  logic [REM_W-1:0] rem_r;
  logic [RW-1:0]    root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [CAT_W-1:0] cat;
  logic [CAT_W-1:0] trial;
  logic [CAT_W-1:0] diff;
  logic             fits;

  // Bring down the next two bits and try to set the next root bit.
  assign cat   = {rem_r, val_r[PAD_W-1 -: 2]};
  assign trial = CAT_W'({root_r, 2'b01});
  assign diff  = cat - trial;
  assign fits  = (cat >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= PAD_W'(value);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r <= val_r << 2;
      if (fits) begin
        rem_r  <= REM_W'(diff);
        root_r <= RW'({root_r, 1'b1});
      end else begin
        rem_r  <= REM_W'(cat);
        root_r <= RW'({root_r, 1'b0});
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/cpbs_checker.sv =====
// Port-level checker for the closest pair search block, bound to the top.
`include "closest_pair_between_two_sets_top_defines.svh"

module cpbs_checker
  import cpbs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [1:0]             in_operation,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_pair_found,
  input logic [INDEX_OUT_W-1:0] out_index_a,
  input logic [INDEX_OUT_W-1:0] out_index_b,
  input logic [LIMIT_W-1:0]     out_best_distance
);

  // A held result keeps its distance and indices.
  `CPBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_best_distance) && $stable(out_index_a) && $stable(out_index_b))

  // A search that finds nothing reports zero indices.
  `CPBS_ASSERT_NOW(a_no_pair_zero_idx, out_valid && !out_pair_found, (out_index_a == '0) && (out_index_b == '0))

  // The block is busy right after it takes a search.
  `CPBS_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (cpbs_op_t'(in_operation) == OP_SEARCH), in_stall)

  // Clears and appends never produce a result.
  `CPBS_ASSERT_NEXT(a_no_spurious_out, !out_valid && in_valid && !in_stall && (cpbs_op_t'(in_operation) != OP_SEARCH), !out_valid)

  // Reset drops any pending result.
  `CPBS_ASSERT_RESET(a_reset_clears_out, !rst_n, !out_valid)

endmodule

bind closest_pair_between_two_sets_top cpbs_checker u_cpbs_checker (.*);
